/* rtl/dlq_pkg.sv */
package dlq_pkg;

   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_RATE_SCALE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DURATION = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TOKENS   = 2'd2;

   localparam logic [15:0] RATE_SCALE_RESET   = 16'd4096;
   localparam logic [9:0]  MAX_DURATION_RESET = 10'd1023;
   localparam logic [12:0] MAX_TOKENS_RESET   = 13'd512;

   localparam logic [1:0] ERR_OK       = 2'd0;
   localparam logic [1:0] ERR_TOKENS   = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW = 2'd2;

   localparam logic [31:0] ONE_Q30      = 32'h4000_0000;
   localparam logic [30:0] LOG2E_Q30    = 31'd1549082005;
   localparam logic [29:0] LN2_Q30      = 30'd744261118;
   localparam logic [30:0] TOTAL_MAX    = 31'h7FFF_FFFF;
   localparam logic [12:0] COUNT_MAX    = 13'h1FFF;
   localparam logic [4:0]  N_MAX        = 5'd22;
   localparam logic [3:0]  HORNER_TERMS = 4'd9;
   localparam logic [47:0] SAT_Q20      = 48'h0100_0000_0000;

   typedef struct packed {
      logic [15:0] rate_scale;
      logic [9:0]  dur_limit;
      logic [12:0] max_tokens;
   } dlq_cfg_type;

   typedef struct packed {
      logic [15:0] frac;
      logic [4:0]  expo;
      logic        huge;
      logic        pos;
      logic        last;
   } dlq_item_type;

   typedef struct packed {
      logic [9:0]  frames;
      logic [30:0] running;
      logic [1:0]  status;
      logic        last;
   } dlq_result_type;

endpackage

/* rtl/dlq_front.sv */
module dlq_front import dlq_pkg::*; #(
   parameter int FRAC_BITS = 12
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [15:0]  in_logit,
   input  logic         in_last,
   output logic         push,
   output dlq_item_type push_item,
   input  logic         full
);

   localparam int XQ_W   = 31 - FRAC_BITS;
   localparam int YW     = XQ_W + 1;
   localparam int PROD_W = XQ_W + 31;

   logic              s1_valid_ff, s1_valid_in;
   logic [15:0]       logit_ff;
   logic              last_ff;
   logic [XQ_W-1:0]   xq;
   logic [PROD_W-1:0] prod;
   logic [YW-1:0]     y;
   logic [YW-1:0]     n_full;
   logic              pos;
   logic              huge;

   assign in_ready = !s1_valid_ff || !full;
   assign push     = s1_valid_ff && !full;

   // x * log2(e) in Q16, rounded to nearest
   assign xq     = XQ_W'(logit_ff[14:0]) << (16 - FRAC_BITS);
   assign prod   = PROD_W'(xq) * PROD_W'(LOG2E_Q30);
   assign y      = YW'((prod + PROD_W'(64'd1 << 29)) >> 30);
   assign n_full = y >> 16;
   assign pos    = (logit_ff != 16'd0) && !logit_ff[15];
   assign huge   = n_full > YW'(N_MAX);

   always_comb begin
      push_item.frac = pos ? y[15:0] : 16'd0;
      push_item.expo = pos ? n_full[4:0] : 5'd0;
      push_item.huge = pos && huge;
      push_item.pos  = pos;
      push_item.last = last_ff;
   end

   always_comb begin
      if (in_valid && in_ready) begin
         s1_valid_in = 1'b1;
      end else if (push) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (in_valid && in_ready) begin
         logit_ff <= in_logit;
         last_ff  <= in_last;
      end
   end

endmodule

/* rtl/dlq_queue.sv */
module dlq_queue import dlq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  dlq_item_type push_item,
   output logic         full,
   input  logic         pop,
   output dlq_item_type pop_item,
   output logic         empty
);

   dlq_item_type entry_ff [2];
   logic         wr_ptr_ff;
   logic         rd_ptr_ff;
   logic [1:0]   count_ff, count_in;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/dlq_back.sv */
module dlq_back import dlq_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  dlq_cfg_type    cfg,
   output logic           pop,
   input  dlq_item_type   pop_item,
   input  logic           empty,
   output logic           out_valid,
   input  logic           out_ready,
   output dlq_result_type out_result
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_T, ST_MUL, ST_DIV, ST_SCALE, ST_ROUND, ST_ACC
   } state_type;

   state_type      state_ff;
   dlq_item_type   item_ff;
   logic [29:0]    t_ff;
   logic [31:0]    p_ff, p_in;
   logic [61:0]    prod_ff;
   logic [3:0]     k_ff;
   logic [47:0]    sp_ff;
   logic [9:0]     whole_ff, whole_in;
   logic [30:0]    total_ff, total_in;
   logic [12:0]    count_ff, count_in;
   logic [1:0]     err_ff, err_in;
   logic           out_valid_ff;
   dlq_result_type result_ff;

   logic [31:0] m;
   logic [32:0] recip;
   logic [5:0]  rshift;
   logic [64:0] qprod;
   logic [31:0] quot;
   logic [4:0]  sh;
   logic [47:0] v;
   logic [47:0] md_q20;
   logic [47:0] vc;
   logic [9:0]  whole;
   logic [19:0] fr;
   logic        inc;
   logic [10:0] whole_r;
   logic [13:0] cnt;
   logic [1:0]  err1;
   logic [31:0] sum;
   logic        ovf;
   logic        acc_fire;

   assign pop        = (state_ff == ST_IDLE) && !empty;
   assign acc_fire   = (state_ff == ST_ACC) && (!out_valid_ff || out_ready);
   assign out_valid  = out_valid_ff;
   assign out_result = result_ff;

   // Horner step: 1 + (t*p >> 30) / k, divide as ceil(2^s/k) multiply then shift by s
   assign m = prod_ff[61:30];
   always_comb begin
      case (k_ff)
         4'd3, 4'd6: recip = 33'd5726623062;
         4'd5:       recip = 33'd6871947674;
         4'd7:       recip = 33'd4908534053;
         4'd9:       recip = 33'd7635497416;
         default:    recip = 33'h1_0000_0000;
      endcase
      case (k_ff)
         4'd1:                   rshift = 6'd32;
         4'd2:                   rshift = 6'd33;
         4'd3, 4'd4:             rshift = 6'd34;
         4'd5, 4'd6, 4'd7, 4'd8: rshift = 6'd35;
         4'd9:                   rshift = 6'd36;
         default:                rshift = 6'd32;
      endcase
   end
   assign qprod = {33'd0, m} * {32'd0, recip};
   assign quot  = 32'(qprod >> rshift);
   assign p_in  = ONE_Q30 + quot;

   // scale to Q20, clamp, round half to even
   assign sh     = N_MAX - item_ff.expo;
   assign md_q20 = {18'd0, cfg.dur_limit, 20'd0};
   always_comb begin
      if (item_ff.huge) begin
         v = (cfg.rate_scale != 16'd0) ? SAT_Q20 : 48'd0;
      end else begin
         v = sp_ff >> sh;
      end
      vc      = (v > md_q20) ? md_q20 : v;
      whole   = vc[29:20];
      fr      = vc[19:0];
      inc     = (fr > 20'h80000) || ((fr == 20'h80000) && whole[0]);
      whole_r = {1'b0, whole} + {10'd0, inc};
      if (whole_r > {1'b0, cfg.dur_limit}) begin
         whole_r = {1'b0, cfg.dur_limit};
      end
      if (whole_r == 11'd0) begin
         whole_r = 11'd1;
      end
      whole_in = whole_r[9:0];
   end

   // utterance bookkeeping
   always_comb begin
      cnt      = {1'b0, count_ff} + 14'd1;
      err1     = ((cnt > {1'b0, cfg.max_tokens}) && (err_ff == ERR_OK)) ? ERR_TOKENS : err_ff;
      count_in = (cnt > {1'b0, COUNT_MAX}) ? COUNT_MAX : cnt[12:0];
      sum      = {1'b0, total_ff} + {22'd0, whole_ff};
      ovf      = sum > {1'b0, TOTAL_MAX};
      total_in = ovf ? TOTAL_MAX : sum[30:0];
      err_in   = (ovf && (err1 == ERR_OK)) ? ERR_OVERFLOW : err1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         total_ff     <= 31'd0;
         count_ff     <= 13'd0;
         err_ff       <= ERR_OK;
         k_ff         <= HORNER_TERMS;
      end else begin
         if (acc_fire) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (!empty) begin
                  item_ff <= pop_item;
                  p_ff    <= ONE_Q30;
                  k_ff    <= HORNER_TERMS;
                  state_ff <= pop_item.pos ? ST_T : ST_SCALE;
               end
            end
            ST_T: begin
               t_ff     <= 30'(({30'd0, item_ff.frac} * {16'd0, LN2_Q30}) >> 16);
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               prod_ff  <= {32'd0, t_ff} * {30'd0, p_ff};
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               p_ff <= p_in;
               if (k_ff == 4'd1) begin
                  state_ff <= ST_SCALE;
               end else begin
                  k_ff     <= k_ff - 4'd1;
                  state_ff <= ST_MUL;
               end
            end
            ST_SCALE: begin
               sp_ff    <= {16'd0, p_ff} * {32'd0, cfg.rate_scale};
               state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               whole_ff <= whole_in;
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               if (acc_fire) begin
                  result_ff.frames  <= whole_ff;
                  result_ff.running <= total_in;
                  result_ff.status  <= err_in;
                  result_ff.last    <= item_ff.last;
                  if (item_ff.last) begin
                     total_ff <= 31'd0;
                     count_ff <= 13'd0;
                     err_ff   <= ERR_OK;
                  end else begin
                     total_ff <= total_in;
                     count_ff <= count_in;
                     err_ff   <= err_in;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_div_k: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> (k_ff >= 4'd1 && k_ff <= HORNER_TERMS))
      else $error("horner index out of range");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (acc_fire && item_ff.last) |=> (total_ff == 31'd0 && count_ff == 13'd0 && err_ff == ERR_OK))
      else $error("utterance state not cleared on last");

   a_err_latch: assert property (@(posedge clock) disable iff (reset)
      (acc_fire && !item_ff.last && err_ff != ERR_OK) |=> err_ff == $past(err_ff))
      else $error("latched error changed");

   a_total_mono: assert property (@(posedge clock) disable iff (reset)
      (acc_fire && !item_ff.last) |=> total_ff >= $past(total_ff))
      else $error("frame total decreased");

endmodule

/* rtl/duration_logit_quantizer_unit.sv */
// Duration logit quantizer: one Q4.12 log-duration per req beat in, one frame count
// per rsp beat out.
//   req: tdata = logit (signed Q4.12), tlast = end of utterance.
//   rsp: tdata = frames, running frame total, status; tlast echoes the request's tlast.
//   csr: index/data write channel, always ready; write only while the block is idle.
// The back end handles one item at a time; a positive logit passes through its
// nine-step Horner loop (a multiply state and a divide-by-constant state per step),
// while other items go straight to scaling and rounding.
// A two-entry queue between the front (classify, exponent scaling) and the back end
// lets the front accept further beats while the back end works.
// When rsp_tready is low the result holds in the output register; the back end can
// carry one more item up to its accumulate state, then stalls, and req_tready drops
// once the queue and the front register are both full.
// Reset clears the frame total, token count and error status, and restores
// rate scale 4096, duration cap 1023, token limit 512. A tlast beat clears the
// utterance state after its result is formed.
module duration_logit_quantizer_unit import dlq_pkg::*; #(
   parameter int FRAC_BITS     = 12,
   parameter int DURATION_BITS = 10,
   localparam int RSP_TDATA_W  = ((DURATION_BITS + 33 + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [15:0]            req_tdata,   // logit
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // frames, running_frames, status
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [15:0]            csr_data
);

   dlq_cfg_type        cfg_ff;
   logic               q_push;
   dlq_item_type       q_push_item;
   logic               q_full;
   logic               q_pop;
   dlq_item_type       q_pop_item;
   logic               q_empty;
   dlq_result_type     result;
   logic [DURATION_BITS-1:0] frames;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate_scale <= RATE_SCALE_RESET;
         cfg_ff.dur_limit  <= MAX_DURATION_RESET;
         cfg_ff.max_tokens <= MAX_TOKENS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RATE_SCALE:   cfg_ff.rate_scale <= csr_data;
            CSR_MAX_DURATION: cfg_ff.dur_limit  <= csr_data[9:0];
            CSR_MAX_TOKENS:   cfg_ff.max_tokens <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   dlq_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_logit  (req_tdata),
      .in_last   (req_tlast),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full)
   );

   dlq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_pop_item),
      .empty     (q_empty)
   );

   dlq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop        (q_pop),
      .pop_item   (q_pop_item),
      .empty      (q_empty),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign frames    = DURATION_BITS'(result.frames);
   assign rsp_tdata = RSP_TDATA_W'({result.status, result.running, frames});
   assign rsp_tlast = result.last;

endmodule

/* tb/duration_logit_quantizer_unit_tb.sv */
module duration_logit_quantizer_unit_tb;
   import dlq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LOGIT_FRAC     = 12;
   localparam int WATCHDOG_LIMIT = 2000;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [15:0]          req_tdata;   // logit
   logic                 req_tlast;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [47:0]          rsp_tdata;   // frames, running_frames, status
   logic                 rsp_tlast;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [15:0]          csr_data;

   // predictor copy of registers and utterance state
   logic [15:0] rate_q12;
   logic [9:0]  dur_cap;
   logic [12:0] tok_cap;
   logic [30:0] frame_sum;
   logic [12:0] tok_seen;
   logic [1:0]  err_latch;

   dlq_result_type due_durations[$];

   bit bursty = 1'b1;
   int mismatches;
   int results_checked;
   int error_beats;
   int tokens_sent;
   int utterances;
   int reg_writes;
   int quiet_cycles;

   duration_logit_quantizer_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // exp(logit) floored at 1.0, times rate, unsigned Q20
   function automatic logic [63:0] scaled_exp_q20(input logic [15:0] lg, input logic [15:0] rs);
      logic [63:0] poly;
      logic [63:0] xq;
      logic [63:0] y;
      logic [63:0] t;
      int unsigned n;
      poly = 64'(ONE_Q30);
      n = 0;
      if (lg != 16'd0 && !lg[15]) begin
         xq = 64'(lg) << (16 - LOGIT_FRAC);
         y = (xq * 64'(LOG2E_Q30) + (64'd1 << 29)) >> 30;
         t = (64'(y[15:0]) * 64'(LN2_Q30)) >> 16;
         n = 32'(y >> 16);
         for (int k = int'(HORNER_TERMS); k >= 1; k--)
            poly = 64'(ONE_Q30) + ((t * poly) >> 30) / 64'(k);
      end
      if (n > N_MAX)
         return (rs != 16'd0) ? 64'(SAT_Q20) : 64'd0;
      return (poly * 64'(rs)) >> (22 - n);
   endfunction

   function automatic dlq_result_type quantize_token(input logic [15:0] lg, input logic eou);
      dlq_result_type r;
      logic [63:0] v;
      logic [63:0] cap;
      logic [63:0] whole;
      logic [63:0] sum;
      logic [19:0] part;
      logic [13:0] cnt;
      v = scaled_exp_q20(lg, rate_q12);
      cap = 64'(dur_cap) << 20;
      if (v > cap)
         v = cap;
      whole = v >> 20;
      part = v[19:0];
      // round half to even
      if (part > 20'h80000 || (part == 20'h80000 && whole[0]))
         whole = whole + 64'd1;
      if (whole > 64'(dur_cap))
         whole = 64'(dur_cap);
      if (whole == 64'd0)
         whole = 64'd1;
      cnt = 14'(tok_seen) + 14'd1;
      if (cnt > 14'(tok_cap) && err_latch == ERR_OK)
         err_latch = ERR_TOKENS;
      tok_seen = (cnt > 14'(COUNT_MAX)) ? COUNT_MAX : cnt[12:0];
      sum = 64'(frame_sum) + whole;
      if (sum > 64'(TOTAL_MAX)) begin
         sum = 64'(TOTAL_MAX);
         if (err_latch == ERR_OK)
            err_latch = ERR_OVERFLOW;
      end
      frame_sum = sum[30:0];
      r.frames = whole[9:0];
      r.running = frame_sum;
      r.status = err_latch;
      r.last = eou;
      if (eou) begin
         frame_sum = '0;
         tok_seen = '0;
         err_latch = ERR_OK;
      end
      return r;
   endfunction

   function automatic logic [15:0] random_logit();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 65535));
         1: return 16'($urandom_range(32768, 65535));
         default: return 16'($urandom_range(1, 16'h5000));
      endcase
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      mismatches++;
      $display("MISMATCH beat %0d %s: got %0d, expected %0d", results_checked, what, got, want);
   endtask

   task automatic send_token(input logic [15:0] lg, input logic eou);
      int gap;
      gap = (bursty && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= lg;
      req_tlast <= eou;
      do @(posedge clock); while (!req_tready);
      due_durations.push_back(quantize_token(lg, eou));
      tokens_sent++;
      if (eou)
         utterances++;
   endtask

   task automatic quiesce();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (due_durations.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_RATE_SCALE:   rate_q12 = val;
         CSR_MAX_DURATION: dur_cap = val[9:0];
         CSR_MAX_TOKENS:   tok_cap = val[12:0];
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [15:0] rs, input logic [9:0] md, input logic [12:0] mt);
      quiesce();
      write_reg(CSR_RATE_SCALE, rs);
      write_reg(CSR_MAX_DURATION, 16'(md));
      write_reg(CSR_MAX_TOKENS, 16'(mt));
   endtask

   task automatic test_reset_config();
      send_token(16'h0000, 1'b0);
      send_token(16'h0001, 1'b0);
      send_token(16'hFFFF, 1'b0);
      send_token(16'h7FFF, 1'b0);
      send_token(16'h8000, 1'b0);
      send_token(16'h1000, 1'b0);
      send_token(16'h2000, 1'b1);
   endtask

   task automatic test_rate_scale();
      set_config(16'd0, 10'd1023, 13'd512);
      send_token(16'h7FFF, 1'b0);
      send_token(16'h0000, 1'b1);
      set_config(16'hFFFF, 10'd1023, 13'd512);
      send_token(16'h7FFF, 1'b0);
      send_token(16'h8000, 1'b1);
      // 1.5 rounds up to 2, 2.5 rounds down to 2
      set_config(16'h1800, 10'd1023, 13'd512);
      send_token(16'h0000, 1'b0);
      set_config(16'h2800, 10'd1023, 13'd512);
      send_token(16'hFFFB, 1'b1);
   endtask

   task automatic test_duration_cap();
      set_config(16'd4096, 10'd0, 13'd512);
      send_token(16'h7FFF, 1'b0);
      send_token(16'h1000, 1'b0);
      set_config(16'd4096, 10'd1, 13'd512);
      send_token(16'h7FFF, 1'b1);
   endtask

   task automatic test_token_limit();
      set_config(16'd4096, 10'd1023, 13'd0);
      send_token(16'h0800, 1'b0);
      send_token(16'hC000, 1'b1);
      set_config(16'd8192, 10'd1023, 13'd2);
      send_token(16'h0000, 1'b0);
      send_token(16'h3000, 1'b0);
      send_token(16'h7FFF, 1'b0);
      send_token(16'h8000, 1'b1);
      set_config(16'd4096, 10'd1023, 13'd4096);
      send_token(16'h1800, 1'b1);
   endtask

   task automatic test_random_utterances();
      logic [15:0] rs;
      logic [9:0]  md;
      logic [12:0] mt;
      for (int phase = 0; phase < 8; phase++) begin
         rs = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(1, 65535))
                                          : 16'($urandom_range(2048, 8192));
         md = ($urandom_range(0, 1) == 0) ? 10'($urandom_range(1, 1023)) : 10'd1023;
         mt = ($urandom_range(0, 1) == 0) ? 13'($urandom_range(1, 24)) : 13'd512;
         set_config(rs, md, mt);
         repeat (42) send_token(random_logit(), $urandom_range(0, 7) == 0);
      end
   endtask

   task automatic test_steady_stream();
      bursty = 1'b0;
      set_config(16'd4096, 10'd1023, 13'd512);
      repeat (39) send_token(random_logit(), $urandom_range(0, 9) == 0);
      send_token(random_logit(), 1'b1);
   endtask

   // sink stalls
   initial begin
      int hold;
      hold = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else if (bursty && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            hold = $urandom_range(1, 3) - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      dlq_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_durations.size() == 0) begin
            report_mismatch("beat with nothing due, frames", rsp_tdata[9:0], 0);
         end else begin
            want = due_durations.pop_front();
            if (rsp_tdata[9:0] !== want.frames)
               report_mismatch("frames", rsp_tdata[9:0], want.frames);
            if (rsp_tdata[40:10] !== want.running)
               report_mismatch("running_frames", rsp_tdata[40:10], want.running);
            if (rsp_tdata[42:41] !== want.status)
               report_mismatch("status", rsp_tdata[42:41], want.status);
            if (rsp_tlast !== want.last)
               report_mismatch("tlast", rsp_tlast, want.last);
            if (want.status != ERR_OK)
               error_beats++;
         end
         results_checked++;
      end
   end

   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT)
            break;
      end
      $display("duration_logit_quantizer_unit_tb: done, errors");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_RATE_SCALE;
      csr_data = '0;
      rate_q12 = RATE_SCALE_RESET;
      dur_cap = MAX_DURATION_RESET;
      tok_cap = MAX_TOKENS_RESET;
      frame_sum = '0;
      tok_seen = '0;
      err_latch = ERR_OK;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_config();
      test_rate_scale();
      test_duration_cap();
      test_token_limit();
      test_random_utterances();
      test_steady_stream();

      quiesce();
      repeat (40) @(posedge clock);
      $display("summary: %0d tokens over %0d utterances, %0d results checked, %0d with error status",
               tokens_sent, utterances, results_checked, error_beats);
      $display("summary: %0d register writes, zero and full-scale rate, caps and token limits",
               reg_writes);
      if (mismatches == 0)
         $display("duration_logit_quantizer_unit_tb: done, clean");
      else
         $display("duration_logit_quantizer_unit_tb: done, errors");
      $finish;
   end

endmodule
